FILE: hw/rtl/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg: shared types and constants for the best-fit heap allocator
// Heap geometry, opcodes and the request struct to the heap memory.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int HEAP_BYTES = 127;
  localparam logic [7:0] HEAP_LIM = 8'(HEAP_BYTES);
  localparam logic [7:0] HEAP_RESET_HDR = 8'((HEAP_BYTES << 1) & 8'hFE);
  localparam logic [6:0] MAX_SIZE = 7'(HEAP_BYTES - 1);

  typedef enum logic [2:0] {
    OP_MALLOC  = 3'd0,
    OP_REALLOC = 3'd1,
    OP_FREE    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_READ    = 3'd4
  } opcode_t;

  // one read address and one write per cycle into the heap memory
  typedef struct packed {
    logic [6:0] raddr;
    logic       we;
    logic [6:0] waddr;
    logic [7:0] wdata;
  } mem_req_t;

endpackage

FILE: hw/rtl/bfha_if.sv
// ----------------------------------------------------------------------------
// bfha_if: request and result channels
// Valid/ready channels carrying the allocator request and result payloads.
// ----------------------------------------------------------------------------
interface bfha_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [6:0] addr;
  logic [6:0] req_size;
  logic [7:0] write_data;
  modport source (output valid, opcode, addr, req_size, write_data, input ready);
  modport sink (input valid, opcode, addr, req_size, write_data, output ready);
endinterface

interface bfha_res_if;
  logic       valid;
  logic       ready;
  logic [6:0] result_addr;
  logic       failed;
  logic [7:0] read_data;
  modport source (output valid, result_addr, failed, read_data, input ready);
  modport sink (input valid, result_addr, failed, read_data, output ready);
endinterface

FILE: hw/rtl/bfha_heap_mem.sv
// ----------------------------------------------------------------------------
// bfha_heap_mem: heap byte store
// One write and one registered read per cycle; per-byte valid bits give the
// reset image (one free block covering the heap) without a clearing pass.
// ----------------------------------------------------------------------------
module bfha_heap_mem import bfha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0]            mem [HEAP_BYTES];
  logic [HEAP_BYTES-1:0] vld;
  logic [7:0]            q;
  logic                  q_vld;
  logic                  q_zero;
  logic                  q_oor;

  // write port
  always_ff @(posedge clk) begin
    if (req.we && (8'(req.waddr) < HEAP_LIM)) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we && (8'(req.waddr) < HEAP_LIM)) begin
      vld[req.waddr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    q_oor  <= !(8'(req.raddr) < HEAP_LIM);
    q_zero <= (req.raddr == 7'd0);
    if (8'(req.raddr) < HEAP_LIM) begin
      q     <= mem[req.raddr];
      q_vld <= vld[req.raddr];
    end else begin
      q     <= 8'd0;
      q_vld <= 1'b0;
    end
  end

  // unwritten bytes read as their reset value
  always_comb begin
    if (q_oor) begin
      rdata = 8'd0;
    end else if (q_vld) begin
      rdata = q;
    end else begin
      rdata = q_zero ? HEAP_RESET_HDR : 8'd0;
    end
  end

endmodule

FILE: hw/rtl/best_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator: implicit free-list heap with best-fit malloc
// Sequencer over a heap store with one read and one write port, running
// malloc, realloc, free and raw byte access.
// ----------------------------------------------------------------------------
// Usage: send one request on req (opcode, addr, req_size, write_data); one
// result comes back on res (result_addr, failed, read_data). req.ready is
// high only while the sequencer is idle; a request is taken while a prior
// result still waits on res. All heap access goes through one memory request
// with a registered read, so each header visit is a read step and a check
// step. After each result the sequencer returns to idle, where it takes the
// next request.
// Reset: synchronous; the heap reads as one free block covering all bytes
// at once, with no clearing pass. A stalled res holds its result, and the
// sequencer waits in its final step until the result register is free.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator import bfha_pkg::*; (
  input  logic clk,
  input  logic rst,
  bfha_req_if.sink   req,
  bfha_res_if.source res
);

  typedef enum logic [4:0] {
    S_IDLE, S_M_RD, S_M_CHK, S_M_END, S_M_SPLIT, S_M_HDR,
    S_R_RD, S_R_CHK, S_R_NRD, S_R_NCHK, S_R_HDR, S_R_TAIL,
    S_CP_RD, S_CP_WR, S_CP_FIN,
    S_F_RD, S_F_CHK, S_F_CLR, S_F_NRD, S_F_NCHK, S_F_MRG,
    S_W_WR, S_B_RD, S_B_Q, S_DONE
  } state_t;

  state_t     state;
  mem_req_t   mreq;
  logic [7:0] q;

  logic       realloc_mode;
  logic [6:0] addr_r;
  logic [6:0] need;
  logic [7:0] wdata_r;
  logic [7:0] cur;
  logic [7:0] best_len;
  logic [6:0] best_pos;
  logic       best_ok;
  logic [6:0] hpos;
  logic [6:0] cb;
  logic [6:0] tail;
  logic [6:0] merged;
  logic [6:0] np;
  logic [6:0] idx;
  logic [6:0] ra_r;
  logic       fail_r;
  logic [7:0] rd_r;
  logic       out_valid;
  logic [6:0] out_addr;
  logic       out_fail;
  logic [7:0] out_data;

  logic [7:0] nxt;
  logic [7:0] src;
  logic [7:0] dst;
  logic [6:0] qlen;
  logic [7:0] sum8;

  assign nxt  = 8'(hpos) + 8'(cb);
  assign src  = 8'(hpos) + 8'd1 + 8'(idx);
  assign dst  = 8'(np) + 8'(idx);
  assign qlen = q[7:1];
  assign sum8 = 8'(cb) + 8'(qlen);

  bfha_heap_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (q)
  );

  // memory request per step
  always_comb begin
    mreq = '0;
    case (state)
      S_M_RD:    mreq.raddr = cur[6:0];
      S_R_RD:    mreq.raddr = hpos;
      S_R_NRD:   mreq.raddr = nxt[6:0];
      S_CP_RD:   mreq.raddr = src[6:0];
      S_F_RD:    mreq.raddr = hpos;
      S_F_NRD:   mreq.raddr = nxt[6:0];
      S_B_RD:    mreq.raddr = addr_r;
      S_M_SPLIT: begin
        mreq.we    = (best_len > 8'(need));
        mreq.waddr = best_pos + need;
        mreq.wdata = {7'(best_len - 8'(need)), 1'b0};
      end
      S_M_HDR: begin
        mreq.we    = 1'b1;
        mreq.waddr = best_pos;
        mreq.wdata = {need, 1'b1};
      end
      S_R_HDR: begin
        mreq.we    = 1'b1;
        mreq.waddr = hpos;
        mreq.wdata = {need, 1'b1};
      end
      S_R_TAIL: begin
        mreq.we    = (tail != 7'd0);
        mreq.waddr = hpos + need;
        mreq.wdata = {tail, 1'b0};
      end
      S_CP_WR: begin
        mreq.we    = (dst < HEAP_LIM) && (src < HEAP_LIM);
        mreq.waddr = dst[6:0];
        mreq.wdata = q;
      end
      S_CP_FIN, S_F_CLR: begin
        mreq.we    = 1'b1;
        mreq.waddr = hpos;
        mreq.wdata = {cb, 1'b0};
      end
      S_F_MRG: begin
        mreq.we    = 1'b1;
        mreq.waddr = hpos;
        mreq.wdata = {merged, 1'b0};
      end
      S_W_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = addr_r;
        mreq.wdata = wdata_r;
      end
      default: mreq = '0;
    endcase
  end

  assign req.ready       = (state == S_IDLE);
  assign res.valid       = out_valid;
  assign res.result_addr = out_addr;
  assign res.failed      = out_fail;
  assign res.read_data   = out_data;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop a taken result unless a new one is loaded below
      if (out_valid && res.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            addr_r  <= req.addr;
            wdata_r <= req.write_data;
            need    <= req.req_size + 7'd1;
            hpos    <= req.addr - 7'd1;
            ra_r    <= 7'd0;
            fail_r  <= 1'b0;
            rd_r    <= 8'd0;
            cur      <= 8'd0;
            best_len <= HEAP_LIM + 8'd1;
            best_ok  <= 1'b0;
            realloc_mode <= 1'b0;
            state   <= S_DONE;
            case (req.opcode)
              OP_MALLOC: begin
                if (req.req_size == 7'd0 || req.req_size > MAX_SIZE) begin
                  fail_r <= 1'b1;
                end else begin
                  state <= S_M_RD;
                end
              end
              OP_REALLOC: begin
                if (req.addr == 7'd0 || req.req_size == 7'd0 ||
                    req.req_size > MAX_SIZE) begin
                  fail_r <= 1'b1;
                end else begin
                  state <= S_R_RD;
                end
              end
              OP_FREE: begin
                if (req.addr != 7'd0 && 8'(req.addr) < HEAP_LIM) begin
                  state <= S_F_RD;
                end
              end
              OP_WRITE: begin
                if (8'(req.addr) < HEAP_LIM) begin
                  state <= S_W_WR;
                end
              end
              OP_READ: begin
                if (8'(req.addr) < HEAP_LIM) begin
                  state <= S_B_RD;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        // best-fit scan over headers
        S_M_RD: begin
          state <= (cur < HEAP_LIM) ? S_M_CHK : S_M_END;
        end
        S_M_CHK: begin
          if (qlen == 7'd0) begin
            state <= S_M_END;
          end else begin
            if (!q[0] && qlen >= need && (cur + 8'(qlen)) <= HEAP_LIM &&
                8'(qlen) < best_len) begin
              best_len <= 8'(qlen);
              best_pos <= cur[6:0];
              best_ok  <= 1'b1;
            end
            cur   <= cur + 8'(qlen);
            state <= S_M_RD;
          end
        end
        S_M_END: begin
          if (best_ok) begin
            state <= S_M_SPLIT;
          end else begin
            fail_r <= 1'b1;
            state  <= S_DONE;
          end
        end
        S_M_SPLIT: state <= S_M_HDR;
        S_M_HDR: begin
          if (realloc_mode) begin
            np    <= best_pos + 7'd1;
            idx   <= 7'd0;
            state <= S_CP_RD;
          end else begin
            ra_r  <= best_pos + 7'd1;
            state <= S_DONE;
          end
        end
        // realloc
        S_R_RD: state <= S_R_CHK;
        S_R_CHK: begin
          cb <= qlen;
          if (qlen == 7'd0 || (8'(hpos) + 8'(qlen)) > HEAP_LIM) begin
            fail_r <= 1'b1;
            state  <= S_DONE;
          end else if (need == qlen) begin
            ra_r  <= addr_r;
            state <= S_DONE;
          end else if (need < qlen) begin
            tail  <= qlen - need;
            state <= S_R_HDR;
          end else if ((8'(hpos) + 8'(qlen)) < HEAP_LIM) begin
            state <= S_R_NRD;
          end else begin
            realloc_mode <= 1'b1;
            state        <= S_M_RD;
          end
        end
        S_R_NRD: state <= S_R_NCHK;
        S_R_NCHK: begin
          if (!q[0] && (nxt + 8'(qlen)) <= HEAP_LIM && sum8 >= 8'(need)) begin
            tail  <= 7'(sum8 - 8'(need));
            state <= S_R_HDR;
          end else begin
            realloc_mode <= 1'b1;
            state        <= S_M_RD;
          end
        end
        S_R_HDR: state <= S_R_TAIL;
        S_R_TAIL: begin
          ra_r  <= addr_r;
          state <= S_DONE;
        end
        // payload copy, one byte per read/write pair
        S_CP_RD: begin
          state <= ((8'(idx) + 8'd1) < 8'(cb)) ? S_CP_WR : S_CP_FIN;
        end
        S_CP_WR: begin
          idx   <= idx + 7'd1;
          state <= S_CP_RD;
        end
        S_CP_FIN: begin
          ra_r  <= np;
          state <= S_DONE;
        end
        // free and forward merge
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          cb    <= qlen;
          state <= q[0] ? S_F_CLR : S_DONE;
        end
        S_F_CLR: state <= (nxt < HEAP_LIM) ? S_F_NRD : S_DONE;
        S_F_NRD: state <= S_F_NCHK;
        S_F_NCHK: begin
          merged <= sum8[6:0];
          if (!q[0] && sum8 <= (HEAP_LIM - 8'(hpos))) begin
            state <= S_F_MRG;
          end else begin
            state <= S_DONE;
          end
        end
        S_F_MRG: state <= S_DONE;
        // raw byte access
        S_W_WR: state <= S_DONE;
        S_B_RD: state <= S_B_Q;
        S_B_Q: begin
          rd_r  <= q;
          state <= S_DONE;
        end
        // hand over the result once the output register is free
        S_DONE: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_addr  <= ra_r;
            out_fail  <= fail_r;
            out_data  <= rd_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the best-fit heap allocator
// Mirrors the heap in a local byte array, predicts each response and checks
// result_addr, failed and read_data in order, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
  import bfha_pkg::*;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] addr;
    logic [6:0] req_size;
    logic [7:0] write_data;
  } request_t;

  typedef struct packed {
    logic [6:0] result_addr;
    logic       failed;
    logic [7:0] read_data;
  } response_t;

  localparam int LIMIT_CYCLES = 3_000_000;

  logic clk;
  logic rst;

  bfha_req_if req_ch ();
  bfha_res_if res_ch ();

  best_fit_heap_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .res (res_ch.source)
  );

  request_t  pending_requests[$];
  response_t expected_responses[$];
  logic [7:0] heap_mirror[HEAP_BYTES];
  logic [6:0] live_blocks[$];
  int errors = 0;
  int cycles;
  int send_gap;
  int recv_gap;
  bit hold_off;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mismatch reporting
  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Heap mirror helpers
  function automatic int hdr_len(input int pos);
    return heap_mirror[pos][7:1];
  endfunction

  function automatic int mirror_malloc(input int size);
    int cur, best_len, best, need, len;
    if (size == 0 || size > HEAP_BYTES - 1) return 0;
    need = size + 1;
    cur = 0;
    best_len = HEAP_BYTES + 1;
    best = -1;
    while (cur < HEAP_BYTES) begin
      len = hdr_len(cur);
      if (len == 0) break;
      if (!heap_mirror[cur][0] && len >= need && cur + len <= HEAP_BYTES && len < best_len) begin
        best_len = len;
        best = cur;
      end
      cur += len;
    end
    if (best < 0) return 0;
    len = hdr_len(best);
    if (len > need) heap_mirror[best + need] = 8'((len - need) << 1);
    heap_mirror[best] = 8'((need << 1) | 1);
    return best + 1;
  endfunction

  function automatic int mirror_realloc(input int addr, input int size);
    int h, cb, nb, nxt, ns, rem, np, d, s;
    if (addr == 0 || addr > HEAP_BYTES || size == 0 || size > HEAP_BYTES - 1) return 0;
    h = addr - 1;
    cb = hdr_len(h);
    if (cb == 0 || h + cb > HEAP_BYTES) return 0;
    nb = size + 1;
    if (nb == cb) return addr;
    if (nb < cb) begin
      heap_mirror[h] = 8'((nb << 1) | 1);
      heap_mirror[h + nb] = 8'((cb - nb) << 1);
      return addr;
    end
    nxt = h + cb;
    if (nxt < HEAP_BYTES && !heap_mirror[nxt][0]) begin
      ns = hdr_len(nxt);
      if (nxt + ns <= HEAP_BYTES && cb + ns >= nb) begin
        rem = cb + ns - nb;
        heap_mirror[h] = 8'((nb << 1) | 1);
        if (rem > 0) heap_mirror[h + nb] = 8'(rem << 1);
        return addr;
      end
    end
    np = mirror_malloc(size);
    if (np == 0) return 0;
    for (int i = 0; i + 1 < cb; i++) begin
      d = np + i;
      s = h + 1 + i;
      if (d < HEAP_BYTES && s < HEAP_BYTES) heap_mirror[d] = heap_mirror[s];
    end
    heap_mirror[h] = 8'(cb << 1);
    return np;
  endfunction

  function automatic void mirror_free(input int addr);
    int h, cb, nxt, merged;
    if (addr == 0 || addr >= HEAP_BYTES) return;
    h = addr - 1;
    if (!heap_mirror[h][0]) return;
    heap_mirror[h][0] = 1'b0;
    cb = hdr_len(h);
    nxt = h + cb;
    if (nxt < HEAP_BYTES && !heap_mirror[nxt][0]) begin
      merged = cb + hdr_len(nxt);
      if (merged <= HEAP_BYTES - h) heap_mirror[h] = 8'(merged << 1);
    end
  endfunction

  // Predict the response of one accepted request and advance the mirror
  function automatic response_t predict_response(input request_t rq);
    response_t rs;
    int ra;
    rs = '0;
    case (rq.opcode)
      OP_MALLOC: begin
        ra = mirror_malloc(rq.req_size);
        rs.result_addr = 7'(ra);
        rs.failed = (ra == 0);
      end
      OP_REALLOC: begin
        ra = mirror_realloc(rq.addr, rq.req_size);
        rs.result_addr = 7'(ra);
        rs.failed = (ra == 0);
      end
      OP_FREE: mirror_free(rq.addr);
      OP_WRITE: if (rq.addr < HEAP_BYTES) heap_mirror[rq.addr] = rq.write_data;
      OP_READ: if (rq.addr < HEAP_BYTES) rs.read_data = heap_mirror[rq.addr];
      default: ;
    endcase
    return rs;
  endfunction

  function automatic request_t make_request(input logic [2:0] op, input int addr,
                                            input int size, input int data);
    request_t rq;
    rq.opcode = op;
    rq.addr = 7'(addr);
    rq.req_size = 7'(size);
    rq.write_data = 8'(data);
    return rq;
  endfunction

  // Stimulus-side tracking of blocks believed allocated, so well-formed
  // sequences free and resize real blocks
  function automatic int pick_live();
    if (live_blocks.size() == 0) return $urandom_range(0, 127);
    return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
  endfunction

  // Driver: issue pending requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap <= 0;
      foreach (heap_mirror[i]) heap_mirror[i] = '0;
      heap_mirror[0] = HEAP_RESET_HDR;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_responses.push_back(predict_response(pending_requests.pop_front()));
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold request until taken
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_requests.size() > 0 && !hold_off) begin
        request_t nx;
        nx = pending_requests[0];
        req_ch.valid <= 1'b1;
        req_ch.opcode <= nx.opcode;
        req_ch.addr <= nx.addr;
        req_ch.req_size <= nx.req_size;
        req_ch.write_data <= nx.write_data;
        send_gap <= random_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: stall the result side and check each response
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_gap <= 0;
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (res_ch.valid && res_ch.ready) begin
        if (expected_responses.size() == 0) begin
          report("unexpected response", 0, 0);
        end else begin
          response_t want;
          want = expected_responses.pop_front();
          if (res_ch.result_addr !== want.result_addr)
            report("result_addr", res_ch.result_addr, want.result_addr);
          if (res_ch.failed !== want.failed)
            report("failed", res_ch.failed, want.failed);
          if (res_ch.read_data !== want.read_data)
            report("read_data", res_ch.read_data, want.read_data);
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        recv_gap <= random_gap();
      end
      if (cycles > LIMIT_CYCLES) begin
        $display("[best_fit_heap_allocator] ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    request_t rq;
    int r;
    hold_off = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: bad sizes, full heap, unused opcodes, raw access extremes
    pending_requests.push_back(make_request(OP_READ, 0, 0, 0));
    pending_requests.push_back(make_request(OP_MALLOC, 0, 0, 0));
    pending_requests.push_back(make_request(OP_MALLOC, 0, 127, 0));
    pending_requests.push_back(make_request(OP_MALLOC, 0, 126, 0));
    pending_requests.push_back(make_request(OP_MALLOC, 0, 1, 0));
    pending_requests.push_back(make_request(OP_FREE, 1, 0, 0));
    pending_requests.push_back(make_request(OP_FREE, 1, 0, 0));
    pending_requests.push_back(make_request(OP_MALLOC, 0, 10, 0));
    pending_requests.push_back(make_request(OP_MALLOC, 0, 20, 0));
    pending_requests.push_back(make_request(OP_WRITE, 5, 0, 8'hFF));
    pending_requests.push_back(make_request(OP_REALLOC, 1, 40, 0));
    pending_requests.push_back(make_request(OP_READ, 5, 0, 0));
    pending_requests.push_back(make_request(OP_REALLOC, 0, 5, 0));
    pending_requests.push_back(make_request(OP_REALLOC, 12, 0, 0));
    pending_requests.push_back(make_request(OP_REALLOC, 12, 127, 0));
    pending_requests.push_back(make_request(OP_REALLOC, 12, 20, 0));
    pending_requests.push_back(make_request(OP_REALLOC, 12, 4, 0));
    pending_requests.push_back(make_request(OP_FREE, 127, 0, 0));
    pending_requests.push_back(make_request(OP_FREE, 0, 0, 0));
    pending_requests.push_back(make_request(OP_WRITE, 127, 0, 8'hAA));
    pending_requests.push_back(make_request(OP_READ, 127, 0, 0));
    pending_requests.push_back(make_request(3'd5, 3, 3, 3));
    pending_requests.push_back(make_request(3'd7, 127, 127, 255));
    pending_requests.push_back(make_request(OP_WRITE, 126, 0, 8'h55));
    pending_requests.push_back(make_request(OP_READ, 126, 0, 0));

    // Drain, then hold the sender until every response has come
    wait (pending_requests.size() == 0);
    hold_off = 1'b1;
    wait (expected_responses.size() == 0 && !req_ch.valid);
    repeat (20) @(posedge clk);
    hold_off = 1'b0;

    // Random: mostly well-formed alloc/resize/free traffic on live blocks,
    // fed a few at a time so returned addresses reach the live list
    for (int n = 0; n < 1700; n++) begin
      wait (pending_requests.size() < 4);
      r = $urandom_range(0, 99);
      if (r < 30) begin
        rq = make_request(OP_MALLOC, $urandom_range(0, 127),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(1, 24),
                          $urandom_range(0, 255));
      end else if (r < 48) begin
        rq = make_request(OP_FREE, pick_live(), $urandom_range(0, 127), $urandom_range(0, 255));
      end else if (r < 62) begin
        rq = make_request(OP_REALLOC, pick_live(),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(1, 30),
                          $urandom_range(0, 255));
      end else if (r < 78) begin
        rq = make_request(OP_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 255));
      end else if (r < 96) begin
        rq = make_request(OP_READ, $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 255));
      end else begin
        rq = make_request(3'($urandom_range(5, 7)), $urandom_range(0, 127),
                          $urandom_range(0, 127), $urandom_range(0, 255));
      end
      pending_requests.push_back(rq);
    end

    // End of run
    wait (pending_requests.size() == 0 && !req_ch.valid && expected_responses.size() == 0);
    repeat (600) @(posedge clk);
    if (errors == 0 && expected_responses.size() == 0) begin
      $display("[best_fit_heap_allocator] OK");
    end else begin
      $display("[best_fit_heap_allocator] ERROR");
    end
    $finish;
  end

  // Keep the live list fed with real payload addresses, newest twelve only
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready && res_ch.result_addr != 0) begin
      live_blocks.push_back(res_ch.result_addr);
      if (live_blocks.size() > 12) void'(live_blocks.pop_front());
    end
  end

endmodule

FILE: filelist.f
hw/rtl/bfha_pkg.sv
hw/rtl/bfha_if.sv
hw/rtl/bfha_heap_mem.sv
hw/rtl/best_fit_heap_allocator.sv
bench/tb.sv
